// ----- rtl/core/isotp_rx_pkg.sv -----
package isotp_rx_pkg;

  // Result kinds
  localparam logic [1:0] RK_PAYLOAD = 2'd0;
  localparam logic [1:0] RK_FLOWCTL = 2'd1;
  localparam logic [1:0] RK_STATUS  = 2'd2;

  // Message status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_TIMEOUT        = 3'd1;
  localparam logic [2:0] ST_UNEXPECTED_PCI = 3'd2;
  localparam logic [2:0] ST_SEQUENCE       = 3'd3;
  localparam logic [2:0] ST_BAD_FRAME      = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_PAD_BYTE   = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd1;
  localparam logic [1:0] CFG_SEP_TIME   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd3;

  // Input kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // PCI frame types (upper nibble of byte 0)
  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [7:0]  FC_CTS      = 8'h30;  // flow status: continue to send
  localparam logic [3:0]  SF_MAX_LEN  = 4'd7;
  localparam logic [11:0] FF_MIN_LEN  = 12'd8;
  localparam logic [2:0]  FF_PAYLOAD  = 3'd6;
  localparam logic [2:0]  CF_PAYLOAD  = 3'd7;
  localparam logic [3:0]  FC_LEN      = 4'd8;
  localparam logic [3:0]  SEQ_FIRST   = 4'd1;

  localparam logic [7:0]  PAD_RST     = 8'hAA;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;

  typedef struct packed {
    logic [7:0]  pad;
    logic [7:0]  bs;
    logic [7:0]  stmin;
    logic [15:0] timeout;
  } cfg_t;

  // Words produced by one item: payload bytes, then optional flow control,
  // then optional status.
  typedef struct packed {
    logic [6:0][7:0] pay;
    logic [2:0]      n_pay;
    logic            fc;
    logic            st_en;
    logic [2:0]      st;
  } burst_t;

  function automatic logic [3:0] burst_len(input burst_t b);
    logic [3:0] fc_n;
    fc_n = b.fc ? FC_LEN : 4'd0;
    return {1'b0, b.n_pay} + fc_n + {3'b000, b.st_en};
  endfunction

endpackage

// ----- rtl/core/isotp_rx_fsm.sv -----
module isotp_rx_fsm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   kind,
  input  logic [7:0][7:0]        frame,
  input  isotp_rx_pkg::cfg_t     cfg,
  output isotp_rx_pkg::burst_t   burst
);
  import isotp_rx_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RECV = 2'b10
  } state_t;

  state_t      state, state_next;
  logic [11:0] total_length, total_length_next;
  logic [11:0] bytes_received, bytes_received_next;
  logic [3:0]  expected_sequence, expected_sequence_next;
  logic [15:0] idle_tick_count, idle_tick_count_next;

  logic [3:0]  pci, low;
  logic [11:0] ff_len, need, rcvd_sum;
  logic [15:0] tick_inc;
  logic [2:0]  take_n;

  always_comb begin
    pci      = frame[0][7:4];
    low      = frame[0][3:0];
    ff_len   = {low, frame[1]};
    tick_inc = idle_tick_count + 16'd1;
    need     = (total_length > bytes_received) ? (total_length - bytes_received) : 12'd0;
    take_n   = (need < 12'd7) ? need[2:0] : CF_PAYLOAD;
    rcvd_sum = bytes_received + {9'd0, take_n};

    state_next             = state;
    total_length_next      = total_length;
    bytes_received_next    = bytes_received;
    expected_sequence_next = expected_sequence;
    idle_tick_count_next   = idle_tick_count;

    burst = '0;
    for (int i = 0; i < 7; i++) begin
      burst.pay[i] = frame[i + 1];
    end

    if (take) begin
      if (kind == KIND_TICK) begin
        if (state == S_RECV) begin
          if (tick_inc >= cfg.timeout) begin
            burst.st_en = 1'b1;
            burst.st    = ST_TIMEOUT;
            state_next  = S_IDLE;
          end else begin
            idle_tick_count_next = tick_inc;
          end
        end
      end else if (state == S_IDLE) begin
        case (pci)
          PCI_SF: begin
            burst.st_en = 1'b1;
            if (low == 4'd0 || low > SF_MAX_LEN) begin
              burst.st = ST_BAD_FRAME;
            end else begin
              burst.n_pay = low[2:0];
              burst.st    = ST_OK;
            end
          end
          PCI_FF: begin
            if (ff_len < FF_MIN_LEN) begin
              burst.st_en = 1'b1;
              burst.st    = ST_BAD_FRAME;
            end else begin
              for (int i = 0; i < 6; i++) begin
                burst.pay[i] = frame[i + 2];
              end
              burst.n_pay            = FF_PAYLOAD;
              burst.fc               = 1'b1;
              state_next             = S_RECV;
              total_length_next      = ff_len;
              bytes_received_next    = {9'd0, FF_PAYLOAD};
              expected_sequence_next = SEQ_FIRST;
              idle_tick_count_next   = '0;
            end
          end
          default: begin
            burst.st_en = 1'b1;
            burst.st    = ST_UNEXPECTED_PCI;
          end
        endcase
      end else if (pci != PCI_CF) begin
        burst.st_en = 1'b1;
        burst.st    = ST_UNEXPECTED_PCI;
        state_next  = S_IDLE;
      end else if (low != expected_sequence) begin
        burst.st_en = 1'b1;
        burst.st    = ST_SEQUENCE;
        state_next  = S_IDLE;
      end else begin
        burst.n_pay            = take_n;
        bytes_received_next    = rcvd_sum;
        expected_sequence_next = expected_sequence + 4'd1;
        idle_tick_count_next   = '0;
        if (rcvd_sum >= total_length) begin
          burst.st_en = 1'b1;
          burst.st    = ST_OK;
          state_next  = S_IDLE;
        end
      end
    end

    // back to idle clears the message context
    if (state_next == S_IDLE) begin
      total_length_next      = '0;
      bytes_received_next    = '0;
      expected_sequence_next = SEQ_FIRST;
      idle_tick_count_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      total_length      <= '0;
      bytes_received    <= '0;
      expected_sequence <= SEQ_FIRST;
      idle_tick_count   <= '0;
    end else begin
      state             <= state_next;
      total_length      <= total_length_next;
      bytes_received    <= bytes_received_next;
      expected_sequence <= expected_sequence_next;
      idle_tick_count   <= idle_tick_count_next;
    end
  end

  a_recv_ctx: assert property (@(posedge clk) disable iff (rst)
    state == S_RECV |-> (bytes_received < total_length) && (total_length >= FF_MIN_LEN))
    else $error("receive context inconsistent");

  a_idle_ctx: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (expected_sequence == SEQ_FIRST) && (idle_tick_count == 16'd0)
                        && (bytes_received == 12'd0))
    else $error("idle context not cleared");

endmodule

// ----- rtl/core/isotp_receive_reassembler_core.sv -----
// Channel  | Direction | Handshake         | Word
// config   | in        | cfg_we            | cfg_index, cfg_data
// frames   | in        | in_valid/in_stall | kind, byte0..byte7
// results  | out       | out_valid/out_stall | result_kind, data_byte, status, last
//
// Each input word yields 0 to 14 result words, delivered one per cycle
// while out_stall is low. The next input word is taken only once the single
// burst register is empty or hands its last word to the output register.
// An input word passes the input, burst and output registers in turn.
// Reset (rst, synchronous) returns to idle and loads the register defaults.
// out_stall holds the output register; the burst and input registers back up
// behind it and raise in_stall.
module isotp_receive_reassembler_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [7:0]  byte0,
  input  logic [7:0]  byte1,
  input  logic [7:0]  byte2,
  input  logic [7:0]  byte3,
  input  logic [7:0]  byte4,
  input  logic [7:0]  byte5,
  input  logic [7:0]  byte6,
  input  logic [7:0]  byte7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [7:0]  data_byte,
  output logic [2:0]  status,
  output logic        last
);
  import isotp_rx_pkg::*;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pad     <= PAD_RST;
      cfg.bs      <= '0;
      cfg.stmin   <= '0;
      cfg.timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAD_BYTE:   cfg.pad     <= cfg_data[7:0];
        CFG_BLOCK_SIZE: cfg.bs      <= cfg_data[7:0];
        CFG_SEP_TIME:   cfg.stmin   <= cfg_data[7:0];
        CFG_TIMEOUT:    cfg.timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic            in_q_valid;
  logic            in_q_kind;
  logic [7:0][7:0] in_q_frame;

  // burst register: what one item still has to emit
  logic       burst_valid;
  burst_t     burst_q;
  logic [3:0] burst_total;
  logic [3:0] idx;

  burst_t     burst_new;
  logic [3:0] new_len;
  logic       out_load, advance, burst_last, burst_free, take;

  assign out_load   = !out_valid || !out_stall;
  assign advance    = burst_valid && out_load;
  assign burst_last = (idx == burst_total - 4'd1);
  assign burst_free = !burst_valid || (advance && burst_last);
  assign take       = in_q_valid && burst_free;
  assign in_stall   = in_q_valid && !burst_free;
  assign new_len    = burst_len(burst_new);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q_kind  <= kind;
      in_q_frame <= {byte7, byte6, byte5, byte4, byte3, byte2, byte1, byte0};
    end
  end

  isotp_rx_fsm u_fsm (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .kind  (in_q_kind),
    .frame (in_q_frame),
    .cfg   (cfg),
    .burst (burst_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      idx         <= '0;
    end else if (take && new_len != 4'd0) begin
      burst_valid <= 1'b1;
      idx         <= '0;
    end else if (advance && burst_last) begin
      burst_valid <= 1'b0;
    end else if (advance) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && new_len != 4'd0) begin
      burst_q     <= burst_new;
      burst_total <= new_len;
    end
  end

  // pick the word at idx: payload, then flow control, then status
  logic [3:0] n_pay, fc_off;
  logic [1:0] w_kind;
  logic [7:0] w_data, fc_byte;
  logic [2:0] w_status;

  always_comb begin
    n_pay  = {1'b0, burst_q.n_pay};
    fc_off = idx - n_pay;
    case (fc_off[2:0])
      3'd0:    fc_byte = FC_CTS;
      3'd1:    fc_byte = cfg.bs;
      3'd2:    fc_byte = cfg.stmin;
      default: fc_byte = cfg.pad;
    endcase
    if (idx < n_pay) begin
      w_kind   = RK_PAYLOAD;
      w_data   = burst_q.pay[idx[2:0]];
      w_status = ST_OK;
    end else if (burst_q.fc && fc_off < FC_LEN) begin
      w_kind   = RK_FLOWCTL;
      w_data   = fc_byte;
      w_status = ST_OK;
    end else begin
      w_kind   = RK_STATUS;
      w_data   = '0;
      w_status = burst_q.st;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= burst_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_kind <= w_kind;
      data_byte   <= w_data;
      status      <= w_status;
      last        <= burst_last;
    end
  end

  a_burst_idx: assert property (@(posedge clk) disable iff (rst)
    burst_valid |-> (burst_total != 4'd0) && (idx < burst_total))
    else $error("burst index beyond burst length");

  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> out_valid)
    else $error("gap inside one item's result words");

  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && burst_valid)
    else $error("input stalled with nothing pending");

endmodule
